### hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: always");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/cds_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// cds_pkg
// Types, codes and the statusword decoder of the CiA 402 drive sequencer.
//------------------------------------------------------------------------------
package cds_pkg;

    localparam int AXIS_COUNT = 6;
    localparam int AXIS_IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    // item commands
    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // axis modes
    localparam logic [1:0] MODE_HOMING = 2'd1;
    localparam logic [1:0] MODE_IP     = 2'd2;

    // controlwords
    localparam logic [15:0] CW_FAULT_RESET   = 16'd128;
    localparam logic [15:0] CW_SHUTDOWN      = 16'd6;
    localparam logic [15:0] CW_SWITCH_ON     = 16'd7;
    localparam logic [15:0] CW_ENABLE_OP     = 16'd15;
    localparam logic [15:0] CW_QS_RELEASE    = 16'd11;
    localparam logic [15:0] CW_DISABLE_VOLT  = 16'd2;
    localparam logic [15:0] CW_OP_START      = 16'd31;

    // statusword masks and patterns
    localparam logic [15:0] SW_MASK_A      = 16'h004F;
    localparam logic [15:0] SW_MASK_B      = 16'h006F;
    localparam logic [15:0] SW_PAT_OFF     = 16'h0000;
    localparam logic [15:0] SW_PAT_DIS     = 16'h0040;
    localparam logic [15:0] SW_PAT_READY   = 16'h0021;
    localparam logic [15:0] SW_PAT_SWON    = 16'h0023;
    localparam logic [15:0] SW_PAT_ENABLED = 16'h0027;
    localparam logic [15:0] SW_PAT_QSTOP   = 16'h0007;
    localparam int          SW_FAULT_BIT   = 3;
    localparam int          SW_TGT_BIT     = 12;
    localparam int          SW_HERR_BIT    = 13;

    typedef enum logic [2:0] {
        ST_NOT_READY   = 3'd0,
        ST_DISABLED    = 3'd1,
        ST_READY       = 3'd2,
        ST_SWITCHED_ON = 3'd3,
        ST_ENABLED     = 3'd4,
        ST_QUICK_STOP  = 3'd5,
        ST_FAULT       = 3'd6,
        ST_UNKNOWN     = 3'd7
    } t_drive_state;

    typedef struct packed {
        logic               cmd;
        logic [2:0]         axis;
        logic [15:0]        status_word;
        logic               emergency_stop;
        logic [1:0]         axis_mode;
        logic signed [31:0] actual_position;
        logic signed [31:0] target_position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         axis_out;
        logic [15:0]        control_word;
        t_drive_state       drive_state;
        logic signed [31:0] position_command;
        logic               position_latched;
        logic               homing_done;
        logic               homing_error;
        logic               joint_error;
    } t_out_item;

    // per-axis store update
    typedef struct packed {
        logic                  wr_en;
        logic [AXIS_IDX_W-1:0] idx;
        logic [15:0]           control_word;
        logic signed [31:0]    position_command;
    } t_axis_wr;

    function automatic t_drive_state decode_state(input logic [15:0] sw);
        logic [15:0] m_a;
        logic [15:0] m_b;
        t_drive_state st;
        m_a = sw & SW_MASK_A;
        m_b = sw & SW_MASK_B;
        if (m_a == SW_PAT_OFF) begin
            st = ST_NOT_READY;
        end else if (m_a == SW_PAT_DIS) begin
            st = ST_DISABLED;
        end else if (m_b == SW_PAT_READY) begin
            st = ST_READY;
        end else if (m_b == SW_PAT_SWON) begin
            st = ST_SWITCHED_ON;
        end else if (m_b == SW_PAT_ENABLED) begin
            st = ST_ENABLED;
        end else if (m_b == SW_PAT_QSTOP) begin
            st = ST_QUICK_STOP;
        end else if (sw[SW_FAULT_BIT]) begin
            st = ST_FAULT;
        end else begin
            st = ST_UNKNOWN;
        end
        return st;
    endfunction

endpackage

### hdl/cds_ifs.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// cds_ifs
// Valid/ready channels carrying sequencer input and result items.
//------------------------------------------------------------------------------
interface cds_in_if import cds_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface cds_out_if import cds_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### hdl/cds_step.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// cds_step
// One control cycle: state decode, controlword choice, homing and
// interpolated position handshakes.
//------------------------------------------------------------------------------
module cds_step import cds_pkg::*; (
    input  t_in_item           i_item,
    input  logic [15:0]        i_held_cw,
    input  logic signed [31:0] i_held_pos,
    output t_out_item          o_res,
    output t_axis_wr           o_wr
);

    t_drive_state       st;
    logic               in_range;
    logic [15:0]        n_cw;
    logic signed [31:0] n_pos;
    logic               latched;
    logic               hdone;
    logic               herr;

    always_comb begin
        st       = decode_state(i_item.status_word);
        in_range = int'(i_item.axis) < AXIS_COUNT;
        n_cw     = i_held_cw;
        n_pos    = i_held_pos;
        latched  = 1'b0;
        hdone    = 1'b0;
        herr     = 1'b0;
        if (!in_range) begin
            n_cw  = '0;
            n_pos = '0;
        end else if (i_item.cmd == CMD_CLEAR) begin
            n_cw = '0;
        end else begin
            unique case (st)
                ST_FAULT:       n_cw = CW_FAULT_RESET;
                ST_DISABLED:    n_cw = CW_SHUTDOWN;
                ST_READY:       n_cw = CW_SWITCH_ON;
                ST_SWITCHED_ON: n_cw = CW_ENABLE_OP;
                ST_QUICK_STOP: begin
                    if (!i_item.emergency_stop) n_cw = CW_QS_RELEASE;
                end
                ST_ENABLED: begin
                    if (i_item.emergency_stop) begin
                        n_cw = CW_DISABLE_VOLT;
                    end else if (i_item.axis_mode == MODE_HOMING) begin
                        if (i_item.status_word[SW_HERR_BIT]) begin
                            herr = 1'b1;
                        end else if (!i_item.status_word[SW_TGT_BIT]) begin
                            n_cw = CW_OP_START;
                        end else if (i_held_cw != CW_ENABLE_OP) begin
                            n_cw  = CW_ENABLE_OP;
                            hdone = 1'b1;
                        end
                    end else if (i_item.axis_mode == MODE_IP) begin
                        n_cw = CW_OP_START;
                        if (!i_item.status_word[SW_TGT_BIT]) begin
                            n_pos   = i_item.actual_position;
                            latched = 1'b1;
                        end else begin
                            n_pos = i_item.target_position;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res.axis_out         = i_item.axis;
    assign o_res.control_word     = n_cw;
    assign o_res.drive_state      = st;
    assign o_res.position_command = n_pos;
    assign o_res.position_latched = latched;
    assign o_res.homing_done      = hdone;
    assign o_res.homing_error     = herr;
    assign o_res.joint_error      = (st != ST_ENABLED);

    assign o_wr.wr_en            = in_range;
    assign o_wr.idx              = AXIS_IDX_W'(i_item.axis);
    assign o_wr.control_word     = n_cw;
    assign o_wr.position_command = n_pos;

endmodule

### hdl/cia402_drive_sequencer.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// cia402_drive_sequencer
// CiA 402 power-state sequencer for several axes: decodes the statusword,
// issues the next controlword and holds the position setpoint per axis.
//------------------------------------------------------------------------------
// channel  dir  handshake          payload
// i_in     in   valid/ready        t_in_item  (cmd, axis, statusword, ...)
// o_out    out  valid/ready        t_out_item (controlword, state, setpoint)
//
// One item per cycle sustained while o_out.ready stays high; a result passes
// through the input register and then the result register before it leaves.
// The per-axis controlword/setpoint store is updated as the result register
// loads, so the next item for the same axis sees it without a bubble.
// Reset clears the valid flags and the per-axis store to zero, ready is low.
// A stalled result holds its register; input is taken while the input
// register is empty or moving forward.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module cia402_drive_sequencer import cds_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cds_in_if.sink         i_in,
    cds_out_if.source      o_out
);

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [15:0]        r_held_cw  [AXIS_COUNT];
    logic signed [31:0] r_held_pos [AXIS_COUNT];

    logic               w_adv;
    logic [15:0]        w_rd_cw;
    logic signed [31:0] w_rd_pos;
    logic               w_rd_ok;
    logic [AXIS_IDX_W-1:0] w_rd_idx;
    t_out_item          n_out;
    t_axis_wr           n_wr;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || w_adv);

    assign w_rd_ok  = int'(r_in.axis) < AXIS_COUNT;
    assign w_rd_idx = AXIS_IDX_W'(r_in.axis);
    assign w_rd_cw  = w_rd_ok ? r_held_cw[w_rd_idx]  : '0;
    assign w_rd_pos = w_rd_ok ? r_held_pos[w_rd_idx] : '0;

    cds_step u_step (
        .i_item     (r_in),
        .i_held_cw  (w_rd_cw),
        .i_held_pos (w_rd_pos),
        .o_res      (n_out),
        .o_wr       (n_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_held_cw[i]  <= '0;
                r_held_pos[i] <= '0;
            end
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv && n_wr.wr_en) begin
                r_held_cw[n_wr.idx]  <= n_wr.control_word;
                r_held_pos[n_wr.idx] <= n_wr.position_command;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_in <= i_in.item;
        if (w_adv) r_out <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    `ASSERT_IMPLIES(a_joint_err, i_clk, i_rst_n, r_out_valid,
                    r_out.joint_error == (r_out.drive_state != ST_ENABLED))
    `ASSERT_IMPLIES(a_latch_ip, i_clk, i_rst_n, r_out_valid && r_out.position_latched,
                    r_out.drive_state == ST_ENABLED && r_out.control_word == CW_OP_START)
    `ASSERT_IMPLIES(a_home_done, i_clk, i_rst_n, r_out_valid && r_out.homing_done,
                    r_out.control_word == CW_ENABLE_OP && !r_out.homing_error)
    `ASSERT_ALWAYS(a_out_load, i_clk, i_rst_n, !$rose(r_out_valid) || $past(w_adv))

endmodule

### tb/cia402_drive_sequencer_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// cia402_drive_sequencer_test
// Drives statusword items into the drive sequencer over valid/ready, predicts
// the controlword, drive state, setpoint and event flags of each item with a
// per-axis model of its own, and checks every result in order. Directed
// corner cases come first, then random power-up and handshake sequences mixed
// with noise, under bursty input and a stalling result side.
//------------------------------------------------------------------------------
module cia402_drive_sequencer_test;
    import cds_pkg::*;

    localparam int          RANDOM_ITEMS = 1725;
    localparam int          CHUNK_ITEMS  = 350;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [15:0] SW_FREE_BITS = 16'hCF90;
    localparam logic [15:0] SW_TGT       = 16'd1 << SW_TGT_BIT;
    localparam logic [15:0] SW_HERR      = 16'd1 << SW_HERR_BIT;
    localparam logic [15:0] SW_ALL_SET   = 16'hFFFF;
    localparam logic [15:0] SW_ODD_LOW   = 16'h0001;
    localparam logic [1:0]  MODE_NONE    = 2'd0;
    localparam logic [1:0]  MODE_SPARE   = 2'd3;

    typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PERIODIC} t_ready_style;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    t_in_item in_item   = '0;
    logic     out_ready = 1'b0;

    cds_in_if  in_ch ();
    cds_out_if out_ch ();

    assign in_ch.valid  = in_valid;
    assign in_ch.item   = in_item;
    assign out_ch.ready = out_ready;

    cia402_drive_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_in_item  pending_cycles[$];
    t_out_item awaited_outputs[$];

    logic [15:0]        cw_store  [AXIS_COUNT] = '{default: '0};
    logic signed [31:0] pos_store [AXIS_COUNT] = '{default: '0};

    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int latch_events  = 0;
    int homing_events = 0;
    int herr_events   = 0;
    int cycle_count   = 0;
    int queued        = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int style_left    = 0;
    int style_phase   = 0;
    logic         in_took     = 1'b0;
    t_ready_style ready_style = RDY_ALWAYS;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_drive_state state_of(input logic [15:0] sw);
        t_drive_state st;
        if ({sw[6], sw[3:0]} == 5'b0_0000) begin
            st = ST_NOT_READY;
        end else if ({sw[6], sw[3:0]} == 5'b1_0000) begin
            st = ST_DISABLED;
        end else begin
            case ({sw[6], sw[5], sw[3:0]})
                6'b01_0001: st = ST_READY;
                6'b01_0011: st = ST_SWITCHED_ON;
                6'b01_0111: st = ST_ENABLED;
                6'b00_0111: st = ST_QUICK_STOP;
                default:    st = sw[SW_FAULT_BIT] ? ST_FAULT : ST_UNKNOWN;
            endcase
        end
        return st;
    endfunction

    // next controlword and setpoint of one axis; updates the per-axis store
    function automatic t_out_item sequence_axis(input t_in_item it);
        t_out_item          r;
        t_drive_state       st;
        logic [15:0]        cw;
        logic signed [31:0] pos;
        st = state_of(it.status_word);
        r = '0;
        r.axis_out    = it.axis;
        r.drive_state = st;
        r.joint_error = (st != ST_ENABLED);
        if (int'(it.axis) < AXIS_COUNT) begin
            cw  = cw_store[it.axis];
            pos = pos_store[it.axis];
            if (it.cmd == CMD_CLEAR) begin
                cw = '0;
            end else begin
                case (st)
                    ST_FAULT:       cw = CW_FAULT_RESET;
                    ST_DISABLED:    cw = CW_SHUTDOWN;
                    ST_READY:       cw = CW_SWITCH_ON;
                    ST_SWITCHED_ON: cw = CW_ENABLE_OP;
                    ST_QUICK_STOP: begin
                        if (!it.emergency_stop) cw = CW_QS_RELEASE;
                    end
                    ST_ENABLED: begin
                        if (it.emergency_stop) begin
                            cw = CW_DISABLE_VOLT;
                        end else if (it.axis_mode == MODE_HOMING) begin
                            if (it.status_word[SW_HERR_BIT]) begin
                                r.homing_error = 1'b1;
                            end else if (!it.status_word[SW_TGT_BIT]) begin
                                cw = CW_OP_START;
                            end else if (cw != CW_ENABLE_OP) begin
                                cw = CW_ENABLE_OP;
                                r.homing_done = 1'b1;
                            end
                        end else if (it.axis_mode == MODE_IP) begin
                            cw = CW_OP_START;
                            if (!it.status_word[SW_TGT_BIT]) begin
                                pos = it.actual_position;
                                r.position_latched = 1'b1;
                            end else begin
                                pos = it.target_position;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            cw_store[it.axis]  = cw;
            pos_store[it.axis] = pos;
            r.control_word     = cw;
            r.position_command = pos;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic check_result(input t_out_item got, input t_out_item want);
        if (got.axis_out !== want.axis_out)
            report_mismatch("axis_out", 32'(got.axis_out), 32'(want.axis_out));
        if (got.control_word !== want.control_word)
            report_mismatch("control_word", 32'(got.control_word), 32'(want.control_word));
        if (got.drive_state !== want.drive_state)
            report_mismatch("drive_state", 32'(got.drive_state), 32'(want.drive_state));
        if (got.position_command !== want.position_command)
            report_mismatch("position_command", got.position_command, want.position_command);
        if (got.position_latched !== want.position_latched)
            report_mismatch("position_latched", 32'(got.position_latched),
                            32'(want.position_latched));
        if (got.homing_done !== want.homing_done)
            report_mismatch("homing_done", 32'(got.homing_done), 32'(want.homing_done));
        if (got.homing_error !== want.homing_error)
            report_mismatch("homing_error", 32'(got.homing_error), 32'(want.homing_error));
        if (got.joint_error !== want.joint_error)
            report_mismatch("joint_error", 32'(got.joint_error), 32'(want.joint_error));
    endtask

    // input acceptance, prediction and result checking
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[cia402_drive_sequencer] ERROR");
            $finish;
        end
        in_took = 1'b0;
        if (i_rst_n && in_valid && in_ch.ready) begin
            want = sequence_axis(in_item);
            awaited_outputs = {awaited_outputs, want};
            void'(pending_cycles.pop_front());
            in_took = 1'b1;
            items_sent++;
            if (want.position_latched) latch_events++;
            if (want.homing_done) homing_events++;
            if (want.homing_error) herr_events++;
        end
        if (i_rst_n && out_ch.valid && out_ready) begin
            got = out_ch.item;
            if (awaited_outputs.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(got.control_word), '0);
            end else begin
                want = awaited_outputs.pop_front();
                check_result(got, want);
                results_seen++;
            end
        end
    end

    // sender: bursts of items with random gaps; valid holds until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (in_took && burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_cycles.size() != 0) begin
                in_valid <= 1'b1;
                in_item  <= pending_cycles[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: changes its stall style every so often
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                ready_style = t_ready_style'($urandom_range(0, 3));
                style_left  = $urandom_range(8, 200);
            end
            style_left--;
            style_phase++;
            case (ready_style)
                RDY_ALWAYS: out_ready <= 1'b1;
                RDY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
                RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:    out_ready <= (style_phase % 5 != 4);
            endcase
        end
    end

    task automatic push_cycle(input logic cmd, input logic [2:0] axis, input logic [15:0] sw,
                              input logic estop, input logic [1:0] mode,
                              input logic signed [31:0] act, input logic signed [31:0] tgt);
        t_in_item it;
        it.cmd             = cmd;
        it.axis            = axis;
        it.status_word     = sw;
        it.emergency_stop  = estop;
        it.axis_mode       = mode;
        it.actual_position = act;
        it.target_position = tgt;
        pending_cycles = {pending_cycles, it};
        queued++;
    endtask

    // statusword that decodes to st, with random don't-care bits
    function automatic logic [15:0] status_for(input t_drive_state st, input logic tgt_bit,
                                               input logic herr_bit);
        logic [15:0] sw;
        sw = 16'($urandom) & SW_FREE_BITS;
        case (st)
            ST_NOT_READY:   sw |= 16'($urandom) & 16'h0020;
            ST_DISABLED:    sw |= SW_PAT_DIS | (16'($urandom) & 16'h0020);
            ST_READY:       sw |= SW_PAT_READY;
            ST_SWITCHED_ON: sw |= SW_PAT_SWON;
            ST_ENABLED:     sw |= SW_PAT_ENABLED;
            ST_QUICK_STOP:  sw |= SW_PAT_QSTOP;
            ST_FAULT:       sw |= (16'd1 << SW_FAULT_BIT) | (16'($urandom) & 16'h0067);
            default: begin
                do begin
                    sw = 16'($urandom) & ~(16'd1 << SW_FAULT_BIT);
                end while (state_of(sw) != ST_UNKNOWN);
            end
        endcase
        sw[SW_TGT_BIT]  = tgt_bit;
        sw[SW_HERR_BIT] = herr_bit;
        return sw;
    endfunction

    // one axis brought up and run through a homing or interpolation handshake, or in an idle mode
    task automatic axis_sequence();
        logic [2:0]         ax;
        logic [1:0]         mode;
        logic signed [31:0] act;
        logic signed [31:0] tgt;
        logic               estop;
        t_drive_state       st;
        int                 pick;
        int                 steps;
        int                 switch_at;
        ax   = 3'($urandom_range(0, AXIS_COUNT - 1));
        pick = $urandom_range(0, 7);
        mode = (pick < 3) ? MODE_HOMING : (pick < 6) ? MODE_IP :
               (pick == 6) ? MODE_NONE : MODE_SPARE;
        act  = 32'($urandom);
        if ($urandom_range(0, 3) == 0)
            push_cycle(CMD_STEP, ax, status_for(ST_FAULT, 1'($urandom), 1'($urandom)),
                       1'($urandom), mode, act, act);
        if ($urandom_range(0, 1) == 0)
            push_cycle(CMD_STEP, ax, status_for(ST_DISABLED, 1'($urandom), 1'($urandom)),
                       1'b0, mode, act, act);
        if ($urandom_range(0, 5) != 0) begin
            push_cycle(CMD_STEP, ax, status_for(ST_READY, 1'($urandom), 1'($urandom)),
                       1'b0, mode, act, act);
            push_cycle(CMD_STEP, ax, status_for(ST_SWITCHED_ON, 1'($urandom), 1'($urandom)),
                       1'b0, mode, act, act);
        end
        steps     = $urandom_range(2, 12);
        switch_at = (mode == MODE_IP) ? $urandom_range(0, 3) : $urandom_range(0, steps);
        for (int k = 0; k < steps; k++) begin
            pick  = $urandom_range(0, 11);
            st    = (pick == 0) ? ST_QUICK_STOP :
                    (pick == 1) ? t_drive_state'($urandom_range(0, 7)) : ST_ENABLED;
            estop = ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 7) == 0) act = 32'($urandom);
            else act = act + 32'($urandom_range(0, 2000)) - 32'sd1000;
            tgt = act + 32'($urandom_range(0, 4000)) - 32'sd2000;
            if ($urandom_range(0, 24) == 0)
                push_cycle(CMD_CLEAR, ax, status_for(st, 1'($urandom), 1'b0), estop, mode,
                           act, tgt);
            else
                push_cycle(CMD_STEP, ax,
                           status_for(st, k >= switch_at, $urandom_range(0, 9) == 0),
                           estop, mode, act, tgt);
        end
    endtask

    task automatic wait_drained();
        while (pending_cycles.size() != 0 || awaited_outputs.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int random_start;
        int chunk_mark;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // power-up ladder on axis 0
        push_cycle(CMD_STEP, 3'd0, SW_PAT_OFF, 1'b0, MODE_NONE, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_DIS, 1'b0, MODE_NONE, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_READY, 1'b0, MODE_NONE, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_SWON, 1'b0, MODE_NONE, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED, 1'b0, MODE_NONE, 32'sd5, 32'sd6);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED, 1'b0, MODE_SPARE, 32'sd5, 32'sd6);
        // homing: start, hold, done once, error bit
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED, 1'b0, MODE_HOMING, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED, 1'b0, MODE_HOMING, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED | SW_TGT, 1'b0, MODE_HOMING, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED | SW_TGT, 1'b0, MODE_HOMING, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED | SW_HERR | SW_TGT, 1'b0, MODE_HOMING,
                   32'sd0, 32'sd0);
        // interpolation: latch, follow, latch at the extremes
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED, 1'b0, MODE_IP, 32'sh80000000, 32'sd1);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED | SW_TGT, 1'b0, MODE_IP, 32'sd1,
                   32'sh7FFFFFFF);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED, 1'b0, MODE_IP, 32'sh7FFFFFFF,
                   32'sh80000000);
        // quick stop held under emergency stop, then released
        push_cycle(CMD_STEP, 3'd0, SW_PAT_QSTOP, 1'b1, MODE_NONE, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_QSTOP, 1'b0, MODE_NONE, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_PAT_ENABLED, 1'b1, MODE_IP, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_ALL_SET, 1'b0, MODE_SPARE, 32'sd0, 32'sd0);
        push_cycle(CMD_STEP, 3'd0, SW_ODD_LOW, 1'b0, MODE_NONE, 32'sd0, 32'sd0);
        push_cycle(CMD_CLEAR, 3'd0, SW_PAT_ENABLED, 1'b0, MODE_IP, 32'sd9, 32'sd9);
        // last axis, then indexes past the axis count
        push_cycle(CMD_STEP, 3'd5, SW_PAT_ENABLED | SW_TGT, 1'b0, MODE_IP, 32'sd0, -32'sd1);
        push_cycle(CMD_STEP, 3'd6, SW_PAT_ENABLED, 1'b0, MODE_IP, -32'sd1, -32'sd1);
        push_cycle(CMD_CLEAR, 3'd7, SW_ALL_SET, 1'b1, MODE_SPARE, -32'sd1, -32'sd1);
        push_cycle(CMD_STEP, 3'd5, SW_ALL_SET, 1'b1, MODE_SPARE, 32'sd0, 32'sd0);
        wait_drained();

        random_start = queued;
        chunk_mark   = queued;
        while (queued - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7)
                axis_sequence();
            else
                push_cycle($urandom_range(0, 7) == 0, 3'($urandom_range(0, 7)),
                           16'($urandom), 1'($urandom), 2'($urandom),
                           32'($urandom), 32'($urandom));
            // stop queueing items until every queued item has been sent and checked
            if (queued - chunk_mark >= CHUNK_ITEMS) begin
                wait_drained();
                chunk_mark = queued;
            end
        end
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d items on axes 0 to 7, %0d results checked", items_sent,
                 results_seen);
        $display("saw %0d setpoint latches, %0d homing completions, %0d homing errors",
                 latch_events, homing_events, herr_events);
        if (mismatches == 0) begin
            $display("[cia402_drive_sequencer] OK");
        end else begin
            $display("[cia402_drive_sequencer] ERROR");
        end
        $finish;
    end

endmodule
